[hw/rtl/json_string_escaper_core_defines.svh]
// assertion macros used by the checker file
`ifndef JSON_STRING_ESCAPER_CORE_DEFINES_SVH
`define JSON_STRING_ESCAPER_CORE_DEFINES_SVH

// next-cycle check, ignored while reset is low
`define JSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle check that also holds through reset
`define JSE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/jse_pkg.sv]
package jse_pkg;

  // fixed widths
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned BYTE_W  = 8;

  // input op codes
  localparam logic [1:0] OP_RAW   = 2'd0;
  localparam logic [1:0] OP_ESC   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // line limit after reset
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 17'h10000;

  // characters used in escapes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CTRL_TOP  = 8'h20;

  // control bytes with a short escape
  localparam logic [7:0] C_NL = 8'h0A;
  localparam logic [7:0] C_CR = 8'h0D;
  localparam logic [7:0] C_HT = 8'h09;
  localparam logic [7:0] C_BS = 8'h08;
  localparam logic [7:0] C_FF = 8'h0C;

  // item kinds after classification
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PLAIN = 2'd0;
  localparam kind_t KIND_PAIR  = 2'd1;
  localparam kind_t KIND_UNI   = 2'd2;
  localparam kind_t KIND_CLEAR = 2'd3;

  typedef logic [2:0] run_len_t;

  // classified item: for a pair the escape letter, else the input byte
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // output bytes produced by one item
  function automatic run_len_t run_len(input kind_t kind);
    run_len_t len;
    case (kind)
      KIND_PLAIN: len = 3'd1;
      KIND_PAIR:  len = 3'd2;
      KIND_UNI:   len = 3'd6;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  // lowercase hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = CH_ZERO + {4'b0, n};
    end else begin
      d = 8'h57 + {4'b0, n};
    end
    return d;
  endfunction

  // byte at position idx of the item's run
  function automatic logic [7:0] run_byte(input kind_t kind, input logic [7:0] data,
                                          input run_len_t idx);
    logic [7:0] b;
    b = data;
    case (kind)
      KIND_PAIR: begin
        b = (idx == 3'd0) ? CH_BSLASH : data;
      end
      KIND_UNI: begin
        case (idx)
          3'd0:    b = CH_BSLASH;
          3'd1:    b = CH_U;
          3'd2:    b = CH_ZERO;
          3'd3:    b = CH_ZERO;
          3'd4:    b = hex_digit(data[7:4]);
          default: b = hex_digit(data[3:0]);
        endcase
      end
      default: b = data;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/jse_front.sv]
module jse_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_op,
  input  logic [7:0]            in_data_byte,
  input  logic                  q_full,
  output logic                  push,
  output jse_pkg::item_t        push_item
);

  logic op_used;

  // classify one input beat
  always_comb begin
    op_used        = 1'b1;
    push_item.kind = jse_pkg::KIND_PLAIN;
    push_item.data = in_data_byte;
    case (in_op)
      jse_pkg::OP_RAW: begin
        push_item.kind = jse_pkg::KIND_PLAIN;
      end
      jse_pkg::OP_ESC: begin
        push_item.kind = jse_pkg::KIND_PAIR;
        case (in_data_byte)
          jse_pkg::CH_QUOTE:  push_item.data = jse_pkg::CH_QUOTE;
          jse_pkg::CH_BSLASH: push_item.data = jse_pkg::CH_BSLASH;
          jse_pkg::C_NL:      push_item.data = jse_pkg::CH_N;
          jse_pkg::C_CR:      push_item.data = jse_pkg::CH_R;
          jse_pkg::C_HT:      push_item.data = jse_pkg::CH_T;
          jse_pkg::C_BS:      push_item.data = jse_pkg::CH_B;
          jse_pkg::C_FF:      push_item.data = jse_pkg::CH_F;
          default: begin
            if (in_data_byte < jse_pkg::CTRL_TOP) begin
              push_item.kind = jse_pkg::KIND_UNI;
            end else begin
              push_item.kind = jse_pkg::KIND_PLAIN;
            end
          end
        endcase
      end
      jse_pkg::OP_CLEAR: begin
        push_item.kind = jse_pkg::KIND_CLEAR;
      end
      default: begin
        // unused op: taken and dropped
        op_used = 1'b0;
      end
    endcase
  end

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && op_used;

endmodule

[hw/rtl/jse_queue.sv]
module jse_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jse_pkg::item_t  push_item,
  input  logic            pop,
  output logic            full,
  output jse_pkg::q_head_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  jse_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head.valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hw/rtl/jse_back.sv]
module jse_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [16:0]           cfg_wdata,
  input  jse_pkg::q_head_t      head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last_of_run,
  output logic                  out_line_truncated
);

  logic [jse_pkg::COUNT_W-1:0] max_r;
  logic [jse_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                        trunc_r, trunc_nxt;

  // run being expanded
  logic                 cur_valid_r, cur_valid_nxt;
  jse_pkg::kind_t       cur_kind_r;
  logic [7:0]           cur_data_r;
  jse_pkg::run_len_t    cur_idx_r;
  jse_pkg::run_len_t    cur_kept_r;
  logic                 cur_trunc_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_trunc_r;

  logic                        out_load, emit, last_beat, cur_done, load_cur;
  jse_pkg::run_len_t           len, kept;
  logic [jse_pkg::COUNT_W-1:0] avail;
  logic                        under_limit, fits, trunc_after;

  assign out_load  = !out_valid_r || !out_stall;
  assign emit      = cur_valid_r && out_load;
  assign last_beat = (cur_idx_r == cur_kept_r - 3'd1);
  assign cur_done  = emit && last_beat;
  assign pop       = head.valid && (!cur_valid_r || cur_done);

  // how much of the next run fits in the line
  always_comb begin
    len         = jse_pkg::run_len(head.item.kind);
    under_limit = (count_r < max_r);
    avail       = max_r - count_r;
    fits        = (avail >= {{(jse_pkg::COUNT_W-3){1'b0}}, len});
    if (trunc_r || !under_limit) begin
      kept        = 3'd0;
      trunc_after = 1'b1;
    end else if (fits) begin
      kept        = len;
      trunc_after = 1'b0;
    end else begin
      kept        = avail[2:0];
      trunc_after = 1'b1;
    end
  end

  // line count and sticky flag move when a run leaves the queue
  always_comb begin
    count_nxt     = count_r;
    trunc_nxt     = trunc_r;
    load_cur      = 1'b0;
    cur_valid_nxt = cur_valid_r && !cur_done;
    if (pop) begin
      if (head.item.kind == jse_pkg::KIND_CLEAR) begin
        count_nxt = '0;
        trunc_nxt = 1'b0;
      end else begin
        count_nxt = count_r + {{(jse_pkg::COUNT_W-3){1'b0}}, kept};
        trunc_nxt = trunc_after;
        if (kept != 3'd0) begin
          load_cur      = 1'b1;
          cur_valid_nxt = 1'b1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= jse_pkg::LIMIT_RESET;
      count_r     <= '0;
      trunc_r     <= 1'b0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      trunc_r     <= trunc_nxt;
      cur_valid_r <= cur_valid_nxt;
      if (out_load) begin
        out_valid_r <= cur_valid_r;
      end
    end
  end

  // run registers
  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_kind_r  <= head.item.kind;
      cur_data_r  <= head.item.data;
      cur_kept_r  <= kept;
      cur_trunc_r <= trunc_after;
      cur_idx_r   <= 3'd0;
    end else if (emit) begin
      cur_idx_r <= cur_idx_r + 3'd1;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r  <= jse_pkg::run_byte(cur_kind_r, cur_data_r, cur_idx_r);
      out_last_r  <= last_beat;
      out_trunc_r <= cur_trunc_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_last_of_run    = out_last_r;
  assign out_line_truncated = out_trunc_r;

endmodule

[hw/rtl/json_string_escaper_core.sv]
// JSON string escaper with a per-line byte limit. Each input beat is a raw byte, a string
// byte to escape, or a line clear; escaped bytes expand to 1, 2 or 6 output beats. Plain
// bytes stream at one beat per clock while out_stall is low; an input item holds the
// expander until all its bytes have left, and the input stalls only once the queue of
// QUEUE_DEPTH classified items between the classifier and the expander has filled.
// A clear or an item whose bytes are all dropped yields no beat. An input beat passes the
// queue, the run registers and the output register before its first output beat. Once the
// line limit is reached, later bytes drop until a clear; line_truncated marks cut runs.
module json_string_escaper_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_line_truncated
);

  logic             q_full;
  logic             push;
  logic             pop;
  jse_pkg::item_t   push_item;
  jse_pkg::q_head_t head;

  // classify input beats
  jse_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  // decoupling queue
  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .head      (head)
  );

  // expand runs, apply the line limit
  jse_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_last_of_run    (out_last_of_run),
    .out_line_truncated (out_line_truncated)
  );

endmodule

[hw/rtl/jse_checker.sv]
`include "json_string_escaper_core_defines.svh"

module jse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_of_run,
  input logic       out_line_truncated
);

  logic       beat_held;
  logic       beat_mid;
  logic [9:0] beat_payload;

  // beat offered but stalled, and beat taken inside a run
  assign beat_held    = out_valid && out_stall;
  assign beat_mid     = out_valid && !out_stall && !out_last_of_run;
  assign beat_payload = {out_byte, out_last_of_run, out_line_truncated};

  // no beat offered right after reset
  `JSE_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid, "out_valid after reset")

  // a stalled beat stays offered
  `JSE_ASSERT_NEXT(a_valid_holds, clk, rst_n, beat_held, out_valid, "beat withdrawn")

  // a stalled beat keeps its payload
  `JSE_ASSERT_NEXT(a_payload_holds, clk, rst_n, beat_held, $stable(beat_payload), "payload moved")

  // a run keeps streaming until its last beat
  `JSE_ASSERT_NEXT(a_run_streams, clk, rst_n, beat_mid, out_valid, "gap inside a run")

  // truncation flag is the same on every beat of a run
  `JSE_ASSERT_NEXT(a_run_flag, clk, rst_n, beat_mid, $stable(out_line_truncated), "run flag moved")

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_byte           (out_byte),
  .out_last_of_run    (out_last_of_run),
  .out_line_truncated (out_line_truncated)
);
